// File: src/gfde_pkg.sv
// Shared types and constants of the GPS fix delta encoder.
package gfde_pkg;

   localparam logic [1:0]  CSR_TIMEZONE = 2'd0;
   localparam logic [1:0]  CSR_LIMIT    = 2'd1;
   localparam logic [14:0] LIMIT_RESET  = 15'd30000;

   typedef struct packed {
      logic [20:0]        calendar_date;
      logic [16:0]        clock_time;
      logic signed [30:0] nanoseconds;
      logic signed [31:0] ground_speed;
      logic [30:0]        speed_accuracy;
      logic signed [30:0] latitude;
      logic signed [31:0] longitude;
      logic [25:0]        heading;
      logic [15:0]        dilution;
      logic [7:0]         satellites;
      logic [2:0]         fix_kind;
      logic               force_full;
   } fix_item_type;

   typedef struct packed {
      logic stage1;
      logic stage2;
      logic stage3;
   } conv_en_type;

   typedef struct packed {
      logic               is_full;
      logic [15:0]        dilution_out;
      logic signed [47:0] time_value;
      logic signed [32:0] speed_value;
      logic signed [31:0] speed_error_value;
      logic signed [31:0] latitude_value;
      logic signed [32:0] longitude_value;
      logic signed [26:0] course_value;
      logic [7:0]         satellites_out;
      logic [2:0]         fix_kind_out;
   } rsp_item_type;

endpackage

// File: src/gfde_fix_conv.sv
// Three-stage conversion of calendar date and clock time to Unix milliseconds.
module gfde_fix_conv import gfde_pkg::*; (
   input  logic               clock,
   input  conv_en_type        en,
   input  fix_item_type       item,
   input  logic [25:0]        heading,
   input  logic signed [16:0] tz_offset,
   output logic signed [47:0] unix_ms,
   output logic [16:0]        course
);

   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      begin
         case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

   // First stage: calendar split, era, day of year, time of day in seconds and nanosecond magnitude.
   logic [11:0]        year;
   logic [3:0]         mon;
   logic [4:0]         day;
   logic signed [13:0] year_adj;
   logic [3:0]         mon_adj;
   logic signed [13:0] yy_full;
   logic [12:0]        yy;
   logic [12:0]        yoe_full;
   logic [3:0]         mp;
   logic [16:0]        tod_u;
   logic signed [31:0] ns_sum;
   logic [31:0]        ns_mag;

   logic [3:0]         era_in, era_ff;
   logic [8:0]         yoe_in, yoe_ff;
   logic signed [9:0]  doy_in, doy_ff;
   logic signed [18:0] tod_s_in, tod_s_ff;
   logic [30:0]        ns_abs_in, ns_abs_ff;
   logic               ns_neg_b_in, ns_neg_b_ff;

   always_comb begin
      year = item.calendar_date[20:9];
      mon  = item.calendar_date[8:5];
      day  = item.calendar_date[4:0];
      if (mon == 4'd0) begin
         year_adj = $signed({2'b00, year}) - 14'sd1;
         mon_adj  = 4'd12;
      end else if (mon >= 4'd13) begin
         year_adj = $signed({2'b00, year}) + 14'sd1;
         mon_adj  = mon - 4'd12;
      end else begin
         year_adj = $signed({2'b00, year});
         mon_adj  = mon;
      end
      yy_full = year_adj + 14'sd400 - ((mon_adj <= 4'd2) ? 14'sd1 : 14'sd0);
      yy      = yy_full[12:0];
      era_in  = 4'd0;
      for (int k = 1; k <= 11; k++) begin
         if (yy >= 13'(k * 400)) begin
            era_in = era_in + 4'd1;
         end
      end
      yoe_full = yy - 13'(era_in) * 13'd400;
      yoe_in   = yoe_full[8:0];
      mp       = (mon_adj >= 4'd3) ? (mon_adj - 4'd3) : (mon_adj + 4'd9);
      doy_in   = $signed({1'b0, month_start(mp)}) + $signed({5'b00000, day}) - 10'sd1;
      tod_u    = 17'(item.clock_time[16:12]) * 17'd3600
               + 17'(item.clock_time[11:6]) * 17'd60
               + 17'(item.clock_time[5:0]);
      tod_s_in = $signed({2'b00, tod_u}) - $signed({{2{tz_offset[16]}}, tz_offset});
      ns_sum   = $signed({item.nanoseconds[30], item.nanoseconds}) + 32'sd500000;
      ns_neg_b_in = ns_sum[31];
      ns_mag    = ns_sum[31] ? (32'd0 - ns_sum) : ns_sum;
      ns_abs_in = ns_mag[30:0];
   end

   always_ff @(posedge clock) begin
      if (en.stage1) begin
         era_ff      <= era_in;
         yoe_ff      <= yoe_in;
         doy_ff      <= doy_in;
         tod_s_ff    <= tod_s_in;
         ns_abs_ff   <= ns_abs_in;
         ns_neg_b_ff <= ns_neg_b_in;
      end
   end

   // Second stage: day count, time of day in milliseconds, rounding and heading quotients.
   logic [18:0]        yoe365;
   logic [15:0]        c100_prod;
   logic [18:0]        doe_u;
   logic signed [19:0] doe;
   logic [20:0]        era_days;
   logic [62:0]        ns_prod;
   logic [52:0]        head_prod;

   logic signed [22:0] days_in, days_ff;
   logic signed [28:0] tod_ms_in, tod_ms_ff;
   logic [11:0]        nq_in, nq_ff;
   logic               ns_neg_c_ff;
   logic [16:0]        course_c_in, course_c_ff;

   always_comb begin
      yoe365    = 19'(yoe_ff) * 19'd365;
      c100_prod = 16'(yoe_ff) * 16'd41;
      doe_u     = yoe365 + 19'(yoe_ff[8:2]) - 19'(c100_prod[15:12]);
      doe       = $signed({1'b0, doe_u}) + $signed({{10{doy_ff[9]}}, doy_ff});
      era_days  = 21'(era_ff) * 21'd146097;
      days_in   = $signed({2'b00, era_days}) + $signed({{3{doe[19]}}, doe}) - 23'sd865565;
      tod_ms_in = $signed({{10{tod_s_ff[18]}}, tod_s_ff}) * 29'sd1000;
      ns_prod   = 63'(ns_abs_ff) * 63'd2251799814;
      nq_in     = ns_prod[62:51];
      head_prod = 53'(heading) * 53'd68719477;
      course_c_in = head_prod[52:36];
   end

   always_ff @(posedge clock) begin
      if (en.stage2) begin
         days_ff     <= days_in;
         tod_ms_ff   <= tod_ms_in;
         nq_ff       <= nq_in;
         ns_neg_c_ff <= ns_neg_b_ff;
         course_c_ff <= course_c_in;
      end
   end

   // Third stage: final millisecond sum and course register.
   logic [47:0]        nq_ext;
   logic signed [47:0] rnd;
   logic signed [47:0] ms_in, ms_ff;
   logic [16:0]        course_d_ff;

   always_comb begin
      nq_ext = {36'd0, nq_ff};
      rnd    = ns_neg_c_ff ? $signed(48'd0 - nq_ext) : $signed(nq_ext);
      ms_in  = $signed({{25{days_ff[22]}}, days_ff}) * 48'sd86400000
             + $signed({{19{tod_ms_ff[28]}}, tod_ms_ff}) + rnd;
   end

   always_ff @(posedge clock) begin
      if (en.stage3) begin
         ms_ff       <= ms_in;
         course_d_ff <= course_c_ff;
      end
   end

   assign unix_ms = ms_ff;
   assign course  = course_d_ff;

endmodule

// File: src/gfde_decide.sv
// Delta formation against the reference fix, frame decision and result register.
module gfde_decide import gfde_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               fire,
   input  logic [14:0]        delta_limit,
   input  logic signed [47:0] unix_ms,
   input  logic [16:0]        course,
   input  fix_item_type       item,
   output rsp_item_type       result
);

   function automatic logic beyond(input logic signed [48:0] d, input logic [14:0] lim);
      logic signed [48:0] l;
      begin
         l = $signed({34'd0, lim});
         return (d > l) || (d < -l);
      end
   endfunction

   logic signed [47:0] ref_time_ff;
   logic signed [31:0] ref_speed_ff;
   logic [30:0]        ref_serr_ff;
   logic signed [30:0] ref_lat_ff;
   logic signed [31:0] ref_lon_ff;
   logic [16:0]        ref_course_ff;
   logic               have_ref_ff;

   logic signed [48:0] dt, ds, de, dla, dlo, dc;
   logic               full;
   rsp_item_type       result_in, result_ff;

   always_comb begin
      dt  = $signed({unix_ms[47], unix_ms}) - $signed({ref_time_ff[47], ref_time_ff});
      ds  = $signed({{17{item.ground_speed[31]}}, item.ground_speed})
          - $signed({{17{ref_speed_ff[31]}}, ref_speed_ff});
      de  = $signed({18'd0, item.speed_accuracy}) - $signed({18'd0, ref_serr_ff});
      dla = $signed({{18{item.latitude[30]}}, item.latitude})
          - $signed({{18{ref_lat_ff[30]}}, ref_lat_ff});
      dlo = $signed({{17{item.longitude[31]}}, item.longitude})
          - $signed({{17{ref_lon_ff[31]}}, ref_lon_ff});
      dc  = $signed({32'd0, course}) - $signed({32'd0, ref_course_ff});
      full = beyond(dt, delta_limit) || beyond(ds, delta_limit) || beyond(de, delta_limit)
          || beyond(dla, delta_limit) || beyond(dlo, delta_limit) || beyond(dc, delta_limit)
          || !have_ref_ff || item.force_full;

      result_in.is_full        = full;
      result_in.dilution_out   = item.dilution;
      result_in.satellites_out = item.satellites;
      result_in.fix_kind_out   = item.fix_kind;
      if (full) begin
         result_in.time_value        = unix_ms;
         result_in.speed_value       = $signed({item.ground_speed[31], item.ground_speed});
         result_in.speed_error_value = $signed({1'b0, item.speed_accuracy});
         result_in.latitude_value    = $signed({item.latitude[30], item.latitude});
         result_in.longitude_value   = $signed({item.longitude[31], item.longitude});
         result_in.course_value      = $signed({1'b0, item.heading});
      end else begin
         result_in.time_value        = dt[47:0];
         result_in.speed_value       = ds[32:0];
         result_in.speed_error_value = de[31:0];
         result_in.latitude_value    = dla[31:0];
         result_in.longitude_value   = dlo[32:0];
         result_in.course_value      = dc[26:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
      if (fire && full) begin
         ref_time_ff   <= unix_ms;
         ref_speed_ff  <= item.ground_speed;
         ref_serr_ff   <= item.speed_accuracy;
         ref_lat_ff    <= item.latitude;
         ref_lon_ff    <= item.longitude;
         ref_course_ff <= course;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ref_ff <= 1'b0;
      end else if (fire && full) begin
         have_ref_ff <= 1'b1;
      end
   end

   assign result = result_ff;

endmodule

// File: src/gps_fix_delta_encoder.sv
// Top level of the GPS fix delta encoder: stream ports, pipeline control and registers.
// One fix is accepted per cycle while the pipeline does not stall; it passes through the input
// register, three conversion stages for the Unix millisecond time and the result register.
// Every stage holds only while the stage after it is full and stalled, so the block keeps
// accepting while a finished frame waits, until every stage is full. The reference fix is
// compared and replaced in the result stage, so each fix is coded against the last full
// frame, including the one just ahead of it. The registers timezone_offset_s (index 0) and
// delta_limit (index 1) must be written by the user through the csr port only while no fix
// is in flight; the block itself does not enforce this.
module gps_fix_delta_encoder import gfde_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // calendar_date, clock_time, nanoseconds, ground_speed, speed_accuracy, latitude,
   // longitude, heading, dilution, satellites, fix_kind
   input  logic [247:0]  req_tdata,
   // force_full
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // dilution_out, time_value, speed_value, speed_error_value, latitude_value,
   // longitude_value, course_value, satellites_out, fix_kind_out
   output logic [231:0]  rsp_tdata,
   // is_full
   output logic          rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [16:0]   csr_data
);

   logic signed [16:0] tz_ff;
   logic [14:0]        limit_ff;

   logic [4:0]         valid_ff, valid_in;
   logic [4:0]         move;
   fix_item_type       item_in;
   fix_item_type       item_ff [4];
   conv_en_type        conv_en;
   logic signed [47:0] unix_ms;
   logic [16:0]        course;
   rsp_item_type       result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff    <= 17'sd0;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIMEZONE: tz_ff    <= $signed(csr_data);
            CSR_LIMIT:    limit_ff <= csr_data[14:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      move[4] = !valid_ff[4] || rsp_tready;
      for (int k = 3; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k + 1];
      end
      valid_in[0] = move[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < 5; k++) begin
         valid_in[k] = move[k] ? valid_ff[k - 1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      item_in.calendar_date  = req_tdata[20:0];
      item_in.clock_time     = req_tdata[37:21];
      item_in.nanoseconds    = req_tdata[68:38];
      item_in.ground_speed   = req_tdata[100:69];
      item_in.speed_accuracy = req_tdata[131:101];
      item_in.latitude       = req_tdata[162:132];
      item_in.longitude      = req_tdata[194:163];
      item_in.heading        = req_tdata[220:195];
      item_in.dilution       = req_tdata[236:221];
      item_in.satellites     = req_tdata[244:237];
      item_in.fix_kind       = req_tdata[247:245];
      item_in.force_full     = req_tuser;
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         item_ff[0] <= item_in;
      end
      for (int k = 1; k < 4; k++) begin
         if (move[k]) begin
            item_ff[k] <= item_ff[k - 1];
         end
      end
   end

   assign conv_en.stage1 = move[1];
   assign conv_en.stage2 = move[2];
   assign conv_en.stage3 = move[3];

   gfde_fix_conv u_conv (
      .clock     (clock),
      .en        (conv_en),
      .item      (item_ff[0]),
      .heading   (item_ff[1].heading),
      .tz_offset (tz_ff),
      .unix_ms   (unix_ms),
      .course    (course)
   );

   gfde_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .load        (move[4]),
      .fire        (move[4] && valid_ff[3]),
      .delta_limit (limit_ff),
      .unix_ms     (unix_ms),
      .course      (course),
      .item        (item_ff[3]),
      .result      (result)
   );

   assign req_tready = move[0];
   assign rsp_tvalid = valid_ff[4];
   assign rsp_tuser  = result.is_full;
   assign rsp_tdata  = {result.fix_kind_out, result.satellites_out, result.course_value,
                        result.longitude_value, result.latitude_value,
                        result.speed_error_value, result.speed_value, result.time_value,
                        result.dilution_out};

endmodule

// File: src/gfde_checker.sv
// Port-level checks of the GPS fix delta encoder and their binding to the top level.
module gfde_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [231:0] rsp_tdata,
   input logic         rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result transaction changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input not ready although no result is waiting");

   a_delta_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         ((&rsp_tdata[63:31]) || !(|rsp_tdata[63:31]))
         && ((&rsp_tdata[220:209]) || !(|rsp_tdata[220:209])))
      else $error("delta frame carries a delta beyond the largest limit");

   a_full_unsigned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[220] && !rsp_tdata[128])
      else $error("full frame carries a negative heading or speed accuracy");

endmodule

bind gps_fix_delta_encoder gfde_checker u_gfde_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: verif/gps_fix_delta_encoder_tb.sv
// Self-checking testbench for the GPS fix delta encoder with a built-in frame predictor.
module gps_fix_delta_encoder_tb import gfde_pkg::*; ();

   localparam int          CYCLE_LIMIT      = 800000;
   localparam int          RANDOM_PER_PHASE = 290;
   localparam int          PHASES           = 6;
   localparam int          REPORT_CAP       = 10;
   localparam logic [1:0]  CSR_SPARE_A      = 2'd2;
   localparam logic [1:0]  CSR_SPARE_B      = 2'd3;

   class fix_frame_scoreboard;
      longint       tz_offset_s;
      longint       limit;
      longint       ref_ms, ref_speed, ref_accuracy, ref_lat, ref_lon, ref_heading;
      bit           have_ref;
      rsp_item_type expected_frames[$];
      int           fail_count;
      int           frames_seen;

      function new();
         tz_offset_s  = 0;
         limit        = longint'(LIMIT_RESET);
         ref_ms       = 0;
         ref_speed    = 0;
         ref_accuracy = 0;
         ref_lat      = 0;
         ref_lon      = 0;
         ref_heading  = 0;
         have_ref     = 1'b0;
         fail_count   = 0;
         frames_seen  = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [16:0] value);
         case (idx)
            CSR_TIMEZONE: tz_offset_s = longint'($signed(value));
            CSR_LIMIT:    limit = longint'(value[14:0]);
            default: ;
         endcase
      endfunction

      function longint days_since_epoch(longint y, longint m, longint d);
         longint yy, era, yoe, mp, doy, doe;
         yy  = y + 400 - ((m <= 2) ? 1 : 0);
         era = yy / 400;
         yoe = yy - era * 400;
         mp  = (m + 9) % 12;
         doy = (153 * mp + 2) / 5 + d - 1;
         doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         return era * 146097 + doe - 719468 - 146097;
      endfunction

      function bit over_limit(longint d);
         return (d > limit) || (d < -limit);
      endfunction

      function void note_fix(fix_item_type f);
         longint       yr, mon0, dy, hr, mi, se, nano, secs, ms;
         longint       spd, acc, lat, lon, hdg;
         longint       d_t, d_s, d_a, d_la, d_lo, d_c;
         bit           full;
         rsp_item_type e;
         yr   = longint'(f.calendar_date[20:9]);
         mon0 = longint'(f.calendar_date[8:5]);
         mon0 = mon0 - 1;
         dy   = longint'(f.calendar_date[4:0]);
         hr   = longint'(f.clock_time[16:12]);
         mi   = longint'(f.clock_time[11:6]);
         se   = longint'(f.clock_time[5:0]);
         nano = longint'($signed(f.nanoseconds));
         spd  = longint'($signed(f.ground_speed));
         acc  = longint'(f.speed_accuracy);
         lat  = longint'($signed(f.latitude));
         lon  = longint'($signed(f.longitude));
         hdg  = longint'(f.heading);
         if (mon0 < 0) begin
            mon0 = mon0 + 12;
            yr   = yr - 1;
         end else if (mon0 >= 12) begin
            mon0 = mon0 - 12;
            yr   = yr + 1;
         end
         secs = days_since_epoch(yr, mon0 + 1, dy) * 86400 + hr * 3600 + mi * 60 + se
                - tz_offset_s;
         ms   = secs * 1000 + (nano + 500000) / 1000000;
         d_t  = ms - ref_ms;
         d_s  = spd - ref_speed;
         d_a  = acc - ref_accuracy;
         d_la = lat - ref_lat;
         d_lo = lon - ref_lon;
         d_c  = hdg / 1000 - ref_heading / 1000;
         full = over_limit(d_t) || over_limit(d_s) || over_limit(d_a) || over_limit(d_la)
                || over_limit(d_lo) || over_limit(d_c) || !have_ref || f.force_full;
         e.is_full        = full;
         e.dilution_out   = f.dilution;
         e.satellites_out = f.satellites;
         e.fix_kind_out   = f.fix_kind;
         if (full) begin
            e.time_value        = 48'(ms);
            e.speed_value       = 33'(spd);
            e.speed_error_value = 32'(acc);
            e.latitude_value    = 32'(lat);
            e.longitude_value   = 33'(lon);
            e.course_value      = 27'(hdg);
            ref_ms       = ms;
            ref_speed    = spd;
            ref_accuracy = acc;
            ref_lat      = lat;
            ref_lon      = lon;
            ref_heading  = hdg;
            have_ref     = 1'b1;
         end else begin
            e.time_value        = 48'(d_t);
            e.speed_value       = 33'(d_s);
            e.speed_error_value = 32'(d_a);
            e.latitude_value    = 32'(d_la);
            e.longitude_value   = 33'(d_lo);
            e.course_value      = 27'(d_c);
         end
         expected_frames.push_back(e);
      endfunction

      function void check_frame(rsp_item_type got);
         rsp_item_type e;
         string        bad;
         frames_seen++;
         if (expected_frames.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
               $display("frame %0d arrived with no fix pending: %h", frames_seen, got);
            return;
         end
         e   = expected_frames.pop_front();
         bad = "";
         if (got.is_full !== e.is_full)                     bad = {bad, " is_full"};
         if (got.dilution_out !== e.dilution_out)           bad = {bad, " dilution_out"};
         if (got.time_value !== e.time_value)               bad = {bad, " time_value"};
         if (got.speed_value !== e.speed_value)             bad = {bad, " speed_value"};
         if (got.speed_error_value !== e.speed_error_value) bad = {bad, " speed_error_value"};
         if (got.latitude_value !== e.latitude_value)       bad = {bad, " latitude_value"};
         if (got.longitude_value !== e.longitude_value)     bad = {bad, " longitude_value"};
         if (got.course_value !== e.course_value)           bad = {bad, " course_value"};
         if (got.satellites_out !== e.satellites_out)       bad = {bad, " satellites_out"};
         if (got.fix_kind_out !== e.fix_kind_out)           bad = {bad, " fix_kind_out"};
         if (bad != "") begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
               $display("frame %0d mismatch in%s: expected %h, got %h",
                        frames_seen, bad, e, got);
         end
      endfunction
   endclass

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [247:0]  req_tdata  = '0;
   logic          req_tuser  = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [231:0]  rsp_tdata;
   logic          rsp_tuser;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index  = '0;
   logic [16:0]   csr_data   = '0;

   fix_frame_scoreboard sb = new();
   fix_item_type        seen_fix;
   rsp_item_type        seen_frame;
   int                  cycle_count = 0;
   int                  rsp_hold    = 0;
   bit                  calm        = 1'b0;
   int                  cur_limit   = int'(LIMIT_RESET);

   gps_fix_delta_encoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int jitter(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [20:0] pack_date(logic [11:0] yr, logic [3:0] mon, logic [4:0] dy);
      return {yr, mon, dy};
   endfunction

   function automatic logic [16:0] pack_clock(logic [4:0] hr, logic [5:0] mi, logic [5:0] se);
      return {hr, mi, se};
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen_frame.is_full = rsp_tuser;
            {seen_frame.fix_kind_out, seen_frame.satellites_out, seen_frame.course_value,
             seen_frame.longitude_value, seen_frame.latitude_value,
             seen_frame.speed_error_value, seen_frame.speed_value, seen_frame.time_value,
             seen_frame.dilution_out} = rsp_tdata;
            sb.check_frame(seen_frame);
         end
         if (req_tvalid && req_tready) begin
            {seen_fix.fix_kind, seen_fix.satellites, seen_fix.dilution, seen_fix.heading,
             seen_fix.longitude, seen_fix.latitude, seen_fix.speed_accuracy,
             seen_fix.ground_speed, seen_fix.nanoseconds, seen_fix.clock_time,
             seen_fix.calendar_date} = req_tdata;
            seen_fix.force_full = req_tuser;
            sb.note_fix(seen_fix);
         end
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(99) < 30)
            rsp_hold = pick_gap();
      end
   end

   task automatic send_fix(input fix_item_type f, input int gap);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {f.fix_kind, f.satellites, f.dilution, f.heading, f.longitude, f.latitude,
                     f.speed_accuracy, f.ground_speed, f.nanoseconds, f.clock_time,
                     f.calendar_date};
      req_tuser  <= f.force_full;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [16:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_frames();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("gps_fix_delta_encoder_tb: FAIL");
      $finish;
   end

   initial begin
      fix_item_type base, f, prev;
      int           k, n, p, r, span;
      int           tz_plan[PHASES];
      int           lim_plan[PHASES];
      tz_plan  = '{0, 3600, -65536, 65535, -50400, 50400};
      lim_plan = '{30000, 30000, 1, 32767, 0, 500};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      base.calendar_date  = pack_date(2021, 6, 15);
      base.clock_time     = pack_clock(12, 30, 45);
      base.nanoseconds    = 0;
      base.ground_speed   = 5000;
      base.speed_accuracy = 200;
      base.latitude       = 475000000;
      base.longitude      = 85000000;
      base.heading        = 9000000;
      base.dilution       = 120;
      base.satellites     = 12;
      base.fix_kind       = 3;
      base.force_full     = 1'b0;
      send_fix(base, pick_gap());

      // Speed and latitude deltas sit exactly at the limit; this stays a delta frame.
      f = base;
      f.nanoseconds  = 400000000;
      f.ground_speed = base.ground_speed + 30000;
      f.latitude     = 31'(base.latitude - 30000);
      f.heading      = 26'(base.heading + 999);
      send_fix(f, pick_gap());

      for (k = 0; k < 6; k++) begin
         f = base;
         case (k)
            0: f.clock_time     = pack_clock(12, 31, 16);
            1: f.ground_speed   = base.ground_speed - 30001;
            2: f.speed_accuracy = 31'(base.speed_accuracy + 30001);
            3: f.latitude       = 31'(base.latitude + 30001);
            4: f.longitude      = base.longitude - 30001;
            default: f.heading  = 26'(base.heading + 30001000);
         endcase
         send_fix(f, pick_gap());
         send_fix(base, pick_gap());
      end

      f = base;
      f.force_full = 1'b1;
      send_fix(f, pick_gap());

      for (k = 0; k < 4; k++) begin
         f = base;
         case (k)
            0: f.nanoseconds = -500000;
            1: f.nanoseconds = -500001;
            2: f.nanoseconds = 1499999;
            default: f.nanoseconds = -1500001;
         endcase
         send_fix(f, pick_gap());
      end

      for (k = 0; k < 5; k++) begin
         f = base;
         case (k)
            0: f.calendar_date = pack_date(2021, 0, 15);
            1: f.calendar_date = pack_date(2021, 13, 1);
            2: f.calendar_date = pack_date(2021, 15, 31);
            3: f.calendar_date = pack_date(2024, 3, 0);
            default: f.clock_time = pack_clock(31, 63, 63);
         endcase
         send_fix(f, pick_gap());
      end

      f.calendar_date  = '1;
      f.clock_time     = '1;
      f.nanoseconds    = 31'h3fffffff;
      f.ground_speed   = 32'h7fffffff;
      f.speed_accuracy = '1;
      f.latitude       = 31'h3fffffff;
      f.longitude      = 32'h7fffffff;
      f.heading        = '1;
      f.dilution       = '1;
      f.satellites     = '1;
      f.fix_kind       = '1;
      f.force_full     = 1'b0;
      send_fix(f, pick_gap());

      f.calendar_date  = '0;
      f.clock_time     = '0;
      f.nanoseconds    = 31'h40000000;
      f.ground_speed   = 32'h80000000;
      f.speed_accuracy = '0;
      f.latitude       = 31'h40000000;
      f.longitude      = 32'h80000000;
      f.heading        = '0;
      f.dilution       = '0;
      f.satellites     = '0;
      f.fix_kind       = '0;
      f.force_full     = 1'b1;
      send_fix(f, pick_gap());
      prev = base;

      for (p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain_frames();
            write_csr(CSR_TIMEZONE, tz_plan[p][16:0]);
            write_csr(CSR_LIMIT, lim_plan[p][16:0]);
            if (p == 3) begin
               write_csr(CSR_SPARE_A, 17'h1ffff);
               write_csr(CSR_SPARE_B, 17'h1ffff);
            end
            cur_limit = lim_plan[p];
         end
         calm = (p == 1) || (p == 4);
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            r = $urandom_range(99);
            if (r < 12) begin
               f.calendar_date  = 21'($urandom);
               f.clock_time     = 17'($urandom);
               f.nanoseconds    = 31'($urandom);
               f.ground_speed   = $urandom;
               f.speed_accuracy = 31'($urandom);
               f.latitude       = 31'($urandom);
               f.longitude      = $urandom;
               f.heading        = 26'($urandom);
               f.dilution       = 16'($urandom);
               f.satellites     = 8'($urandom);
               f.fix_kind       = 3'($urandom);
               f.force_full     = 1'($urandom_range(1));
            end else if (r < 17) begin
               f.calendar_date  = pack_date(12'($urandom_range(1970, 2099)),
                                            4'($urandom_range(1, 12)),
                                            5'($urandom_range(1, 28)));
               f.clock_time     = pack_clock(5'($urandom_range(0, 23)),
                                             6'($urandom_range(0, 59)),
                                             6'($urandom_range(0, 59)));
               f.nanoseconds    = 31'($urandom_range(0, 999999999));
               f.ground_speed   = jitter(60000);
               f.speed_accuracy = 31'($urandom_range(0, 5000));
               f.latitude       = 31'(int'($urandom_range(0, 1800000000)) - 900000000);
               f.longitude      = 32'(longint'($urandom_range(0, 32'd3600000000))
                                      - 1800000000);
               f.heading        = 26'($urandom_range(0, 36000000));
               f.dilution       = 16'($urandom_range(0, 2000));
               f.satellites     = 8'($urandom_range(0, 40));
               f.fix_kind       = 3'($urandom_range(0, 5));
               f.force_full     = 1'b0;
            end else begin
               f = prev;
               f.force_full = ($urandom_range(99) < 4);
               if ($urandom_range(9) != 0) begin
                  span = ($urandom_range(7) == 0) ? cur_limit + 2 : 40;
                  f.nanoseconds = 31'(int'($urandom_range(0, 1998000000)) - 999000000);
                  if ($urandom_range(4) == 0)
                     f.clock_time[5:0] = 6'($urandom_range(0, 63));
                  f.ground_speed   = f.ground_speed + jitter(span);
                  f.speed_accuracy = 31'(f.speed_accuracy + jitter(span));
                  f.latitude       = 31'(f.latitude + jitter(span));
                  f.longitude      = f.longitude + jitter(span);
                  f.heading        = 26'(f.heading + jitter(span) * 1000);
                  f.dilution       = 16'($urandom);
                  f.satellites     = 8'($urandom);
                  f.fix_kind       = 3'($urandom_range(0, 7));
               end
            end
            prev = f;
            send_fix(f, pick_gap());
         end
      end

      drain_frames();
      if (sb.fail_count == 0 && sb.expected_frames.size() == 0)
         $display("gps_fix_delta_encoder_tb: PASS");
      else
         $display("gps_fix_delta_encoder_tb: FAIL");
      $finish;
   end

endmodule
